/* hw/rtl/assert_macros.svh */
// Assertion macros used by the port-level checker.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/htw_pkg.sv */
// ----------------------------------------------------------------------------
// htw_pkg
// Shared constants, types and the timer placement function of the timer wheel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package htw_pkg;

    localparam int WHEEL_SLOT_BITS = 8;
    localparam int TIMER_POOL      = 64;
    localparam int WHEEL_LEVELS    = 4;

    localparam int IDX_W  = $clog2(TIMER_POOL);
    localparam int ID_W   = 6;
    localparam int TO_W   = 32;
    localparam int TICK_W = 64;
    localparam int LVL_W  = 2;
    localparam int WB     = WHEEL_SLOT_BITS;

    localparam logic [TICK_W-1:0] LVL0_SPAN = 64'd1 << WB;
    localparam logic [TICK_W-1:0] LVL1_SPAN = 64'd1 << (2 * WB);
    localparam logic [TICK_W-1:0] LVL2_SPAN = 64'd1 << (3 * WB);
    localparam logic [TICK_W-1:0] MAX_DELAY =
        (64'd1 << (WHEEL_LEVELS * WB)) - 64'd1;

    localparam logic [LVL_W-1:0] LVL_FINE = 2'd0;
    localparam logic [LVL_W-1:0] LVL_TOP  = 2'(WHEEL_LEVELS - 1);

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SCHED  = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_NOP    = 2'd3
    } htw_cmd_t;

    typedef struct packed {
        logic [TICK_W-1:0] expire;
        logic [LVL_W-1:0]  lvl;
        logic [WB-1:0]     slot;
    } htw_entry_t;

    localparam int ENTRY_W = $bits(htw_entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED_ADD,
        ST_SCHED_WR,
        ST_SCAN_RD,
        ST_SCAN_EX,
        ST_END_PASS,
        ST_FLUSH
    } htw_state_t;

    typedef struct packed {
        logic             ready;
        logic             take_in;
        logic             cancel;
        logic             sched_add;
        logic             sched_wr;
        logic             start_pass;
        logic [LVL_W-1:0] pass_lvl;
        logic             rd;
        logic             proc;
        logic             next_idx;
        logic             flush;
        logic             advance;
    } htw_ctl_t;

    typedef struct packed {
        logic             id_ok;
        logic             now_idx_zero;
        logic             pass_slot_zero;
        logic [LVL_W-1:0] pass_lvl;
        logic             act;
        logic             last_idx;
        logic             blocked;
        logic             pend_valid;
        logic             out_free;
    } htw_sts_t;

    // Place an expiry tick relative to base: pick the level from the distance.
    function automatic htw_entry_t htw_place(input logic [TICK_W-1:0] base,
                                             input logic [TICK_W-1:0] expt);
        logic [TICK_W-1:0] diff;
        logic [TICK_W-1:0] e;
        htw_entry_t        r;
        diff = expt - base;
        e    = expt;
        priority if (diff[TICK_W-1])
        begin
            r.lvl  = LVL_FINE;
            r.slot = base[WB-1:0];
        end
        else if (diff < LVL0_SPAN)
        begin
            r.lvl  = LVL_FINE;
            r.slot = e[WB-1:0];
        end
        else if (diff < LVL1_SPAN)
        begin
            r.lvl  = 2'd1;
            r.slot = e[WB +: WB];
        end
        else if (diff < LVL2_SPAN)
        begin
            r.lvl  = 2'd2;
            r.slot = e[2*WB +: WB];
        end
        else
        begin
            // clamp long distances to the longest delay
            if (diff > MAX_DELAY)
            begin
                e = base + MAX_DELAY;
            end
            r.lvl  = LVL_TOP;
            r.slot = e[3*WB +: WB];
        end
        r.expire = e;
        return r;
    endfunction

endpackage

/* hw/rtl/htw_ram.sv */
// ----------------------------------------------------------------------------
// htw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/htw_datapath.sv */
// ----------------------------------------------------------------------------
// htw_datapath
// Tick counter, active bits, entry memory, scan index and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htw_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  htw_pkg::htw_ctl_t         ctl,
    output htw_pkg::htw_sts_t         sts,
    input  logic [htw_pkg::ID_W-1:0]  timer_id,
    input  logic [htw_pkg::TO_W-1:0]  timeout_ticks,
    input  logic                      out_stall,
    output logic                      out_valid,
    output logic [htw_pkg::ID_W-1:0]  expired_id,
    output logic                      last
);
    import htw_pkg::*;

    logic [TICK_W-1:0]     now_reg, now_next;
    logic [TIMER_POOL-1:0] active_reg, active_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [LVL_W-1:0]      pass_reg, pass_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_id_reg, pend_id_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ID_W-1:0]       out_id_reg, out_id_next;
    logic                  out_last_reg, out_last_next;
    logic [IDX_W-1:0]      id_reg;
    logic [TO_W-1:0]       to_reg;
    logic [TICK_W-1:0]     exp_reg;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    htw_entry_t            ram_wdata;
    htw_entry_t            ram_rdata;
    logic [ENTRY_W-1:0]    ram_rbits;
    logic                  hit;
    logic                  out_free;

    function automatic logic [WB-1:0] now_slot(input logic [TICK_W-1:0] t,
                                              input logic [LVL_W-1:0] l);
        logic [WB-1:0] s;
        unique case (l)
            2'd0:    s = t[WB-1:0];
            2'd1:    s = t[WB +: WB];
            2'd2:    s = t[2*WB +: WB];
            default: s = t[3*WB +: WB];
        endcase
        return s;
    endfunction

    htw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TIMER_POOL)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctl.rd),
        .raddr (idx_reg),
        .rdata (ram_rbits)
    );

    assign ram_rdata = htw_entry_t'(ram_rbits);
    assign hit       = (ram_rdata.lvl == pass_reg) &&
                       (ram_rdata.slot == now_slot(now_reg, pass_reg));
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        sts.id_ok          = ({1'b0, timer_id} < (ID_W+1)'(TIMER_POOL));
        sts.now_idx_zero   = (now_reg[WB-1:0] == '0);
        sts.pass_slot_zero = (now_slot(now_reg, pass_reg) == '0);
        sts.pass_lvl       = pass_reg;
        sts.act            = active_reg[idx_reg];
        sts.last_idx       = (idx_reg == IDX_W'(TIMER_POOL - 1));
        sts.blocked        = (pass_reg == LVL_FINE) && hit && pend_valid_reg && !out_free;
        sts.pend_valid     = pend_valid_reg;
        sts.out_free       = out_free;
    end

    // entry memory write: schedule or cascade re-placement
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = htw_place(now_reg, ram_rdata.expire);
        if (ctl.sched_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = id_reg;
            ram_wdata = htw_place(now_reg, exp_reg);
        end
        else if (ctl.proc && (pass_reg != LVL_FINE) && hit)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        now_next        = now_reg;
        active_next     = active_reg;
        idx_next        = idx_reg;
        pass_next       = pass_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;

        if (ctl.cancel)
        begin
            active_next = '0;
        end
        if (ctl.sched_wr)
        begin
            active_next[id_reg] = 1'b1;
        end
        if (ctl.start_pass)
        begin
            pass_next = ctl.pass_lvl;
            idx_next  = '0;
        end
        if (ctl.next_idx)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (ctl.proc && (pass_reg == LVL_FINE) && hit)
        begin
            active_next[idx_reg] = 1'b0;
            // hold the newest hit back until we know whether it is the last
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_id_next    = ID_W'(pend_id_reg);
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_id_next    = idx_reg;
        end
        if (ctl.flush)
        begin
            out_valid_next  = 1'b1;
            out_id_next     = ID_W'(pend_id_reg);
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
        if (ctl.advance)
        begin
            now_next = now_reg + 64'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= '0;
            active_reg     <= '0;
            idx_reg        <= '0;
            pass_reg       <= LVL_FINE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            now_reg        <= now_next;
            active_reg     <= active_next;
            idx_reg        <= idx_next;
            pass_reg       <= pass_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg  <= pend_id_next;
        out_id_reg   <= out_id_next;
        out_last_reg <= out_last_next;
        if (ctl.take_in)
        begin
            id_reg <= timer_id[IDX_W-1:0];
            to_reg <= timeout_ticks;
        end
        if (ctl.sched_add)
        begin
            exp_reg <= now_reg + {{(TICK_W-TO_W){1'b0}}, to_reg};
        end
    end

    assign out_valid  = out_valid_reg;
    assign expired_id = out_id_reg;
    assign last       = out_last_reg;

endmodule

/* hw/rtl/htw_ctrl.sv */
// ----------------------------------------------------------------------------
// htw_ctrl
// Sequencer for schedule, cancel and the cascade and expiry passes of a tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         cmd,
    input  htw_pkg::htw_sts_t  sts,
    output htw_pkg::htw_ctl_t  ctl
);
    import htw_pkg::*;

    htw_state_t state_reg, state_next;
    htw_cmd_t   in_cmd;

    assign in_cmd = htw_cmd_t'(cmd);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_cmd)
                        CMD_TICK:  state_next = ST_SCAN_RD;
                        CMD_SCHED: state_next = sts.id_ok ? ST_SCHED_ADD : ST_IDLE;
                        CMD_CANCEL,
                        CMD_NOP:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCHED_ADD: state_next = ST_SCHED_WR;
            ST_SCHED_WR:  state_next = ST_IDLE;
            ST_SCAN_RD:
            begin
                if (sts.act)
                begin
                    state_next = ST_SCAN_EX;
                end
                else if (sts.last_idx)
                begin
                    state_next = ST_END_PASS;
                end
            end
            ST_SCAN_EX:
            begin
                if (!sts.blocked)
                begin
                    state_next = sts.last_idx ? ST_END_PASS : ST_SCAN_RD;
                end
            end
            ST_END_PASS:
            begin
                if (sts.pass_lvl != LVL_FINE)
                begin
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    state_next = sts.pend_valid ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.ready = 1'b1;
                if (in_valid)
                begin
                    ctl.take_in = 1'b1;
                    ctl.cancel  = (in_cmd == CMD_CANCEL);
                    if (in_cmd == CMD_TICK)
                    begin
                        // cascade level 1 first when the fine index wraps
                        ctl.start_pass = 1'b1;
                        ctl.pass_lvl   = sts.now_idx_zero ? 2'd1 : LVL_FINE;
                    end
                end
            end
            ST_SCHED_ADD: ctl.sched_add = 1'b1;
            ST_SCHED_WR:  ctl.sched_wr  = 1'b1;
            ST_SCAN_RD:
            begin
                if (sts.act)
                begin
                    ctl.rd = 1'b1;
                end
                else if (!sts.last_idx)
                begin
                    ctl.next_idx = 1'b1;
                end
            end
            ST_SCAN_EX:
            begin
                if (!sts.blocked)
                begin
                    ctl.proc     = 1'b1;
                    ctl.next_idx = !sts.last_idx;
                end
            end
            ST_END_PASS:
            begin
                if (sts.pass_lvl != LVL_FINE)
                begin
                    ctl.start_pass = 1'b1;
                    if (sts.pass_slot_zero && (sts.pass_lvl != LVL_TOP))
                    begin
                        ctl.pass_lvl = sts.pass_lvl + 2'd1;
                    end
                    else
                    begin
                        ctl.pass_lvl = LVL_FINE;
                    end
                end
                else if (!sts.pend_valid)
                begin
                    ctl.advance = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    ctl.flush   = 1'b1;
                    ctl.advance = 1'b1;
                end
            end
            default: ctl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/hierarchical_timer_wheel.sv */
// Four-level timer wheel over a pool of 64 timers. Schedule runs through
// ST_SCHED_ADD and ST_SCHED_WR. A tick walks the pool once per pass through
// the entry memory, skipping inactive timers in ST_SCAN_RD and reading
// active ones there for ST_SCAN_EX; up to three cascade passes precede the
// expiry pass when the lower tick indices wrap, each pass ends in ST_END_PASS
// and ST_FLUSH releases the final result. Results leave through a registered
// output, so the next item may be taken while the last result still waits.
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel
// Top level: controller and datapath of the timer wheel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hierarchical_timer_wheel (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                cmd,
    input  logic [htw_pkg::ID_W-1:0]  timer_id,
    input  logic [htw_pkg::TO_W-1:0]  timeout_ticks,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [htw_pkg::ID_W-1:0]  expired_id,
    output logic                      last
);
    import htw_pkg::*;

    htw_ctl_t ctl;
    htw_sts_t sts;

    htw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .sts      (sts),
        .ctl      (ctl)
    );

    htw_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .timer_id      (timer_id),
        .timeout_ticks (timeout_ticks),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .expired_id    (expired_id),
        .last          (last)
    );

    assign in_stall = !ctl.ready;

endmodule

/* hw/rtl/htw_checker.sv */
// ----------------------------------------------------------------------------
// htw_port_props
// Port-level checks of the timer wheel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module htw_port_props (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic [1:0]                cmd,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [htw_pkg::ID_W-1:0]  expired_id,
    input logic                      last
);
    import htw_pkg::*;

    logic in_xfer;

    assign in_xfer = in_valid && !in_stall;

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(expired_id) && $stable(last))
    // a taken tick always leaves the block busy, stalling input
    `ASSERT_NEXT(a_tick_busy, clk, rst_n, in_xfer && (cmd == CMD_TICK), in_stall)
    // cancel-all completes in the transfer cycle
    `ASSERT_NEXT(a_cancel_quick, clk, rst_n, in_xfer && (cmd == CMD_CANCEL), !in_stall)
    // results appear only while a tick is being worked on
    `ASSERT_SAME(a_out_from_tick, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind hierarchical_timer_wheel htw_port_props u_htw_checker (.*);

/* bench/htw_checker.sv */
// ----------------------------------------------------------------------------
// htw_checker
// Watches both channels of the timer wheel, predicts the expired timers of
// every tick transfer and compares them in order with the output transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htw_checker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [1:0]               cmd,
    input  logic [htw_pkg::ID_W-1:0] timer_id,
    input  logic [htw_pkg::TO_W-1:0] timeout_ticks,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [htw_pkg::ID_W-1:0] expired_id,
    input  logic                     last,
    output int                       fail_count,
    output int                       pending_count
);
    import htw_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            last;
    } expiry_t;

    logic [63:0] now_tick;
    logic        busy [TIMER_POOL];
    logic [63:0] due  [TIMER_POOL];
    logic [1:0]  lvl  [TIMER_POOL];
    logic [7:0]  slot [TIMER_POOL];
    expiry_t     expiries [$];

    function automatic void put_timer(int t, logic [63:0] base, logic [63:0] e);
        logic [63:0] d;
        d = e - base;
        busy[t] = 1'b1;
        if (d[63])
        begin
            lvl[t]  = 2'd0;
            slot[t] = base[7:0];
        end
        else if (d < 64'd256)
        begin
            lvl[t]  = 2'd0;
            slot[t] = e[7:0];
        end
        else if (d < 64'd65536)
        begin
            lvl[t]  = 2'd1;
            slot[t] = e[15:8];
        end
        else if (d < 64'd16777216)
        begin
            lvl[t]  = 2'd2;
            slot[t] = e[23:16];
        end
        else
        begin
            if (d > 64'hFFFF_FFFF)
                e = base + 64'hFFFF_FFFF;
            lvl[t]  = 2'd3;
            slot[t] = e[31:24];
        end
        due[t] = e;
    endfunction

    function automatic void cascade_level(logic [1:0] l, logic [7:0] s);
        for (int t = 0; t < TIMER_POOL; t++)
            if (busy[t] && lvl[t] == l && slot[t] == s)
                put_timer(t, now_tick, due[t]);
    endfunction

    function automatic void tick_wheel();
        expiry_t rec;
        int      n;
        n = 0;
        if (now_tick[7:0] == 8'd0)
        begin
            cascade_level(2'd1, now_tick[15:8]);
            if (now_tick[15:8] == 8'd0)
            begin
                cascade_level(2'd2, now_tick[23:16]);
                if (now_tick[23:16] == 8'd0)
                    cascade_level(2'd3, now_tick[31:24]);
            end
        end
        for (int t = 0; t < TIMER_POOL; t++)
            if (busy[t] && lvl[t] == 2'd0 && slot[t] == now_tick[7:0])
            begin
                busy[t]  = 1'b0;
                rec.id   = t[ID_W-1:0];
                rec.last = 1'b0;
                expiries.insert(expiries.size(), rec);
                n++;
            end
        if (n > 0)
            expiries[expiries.size()-1].last = 1'b1;
        now_tick = now_tick + 64'd1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_tick      = '0;
            fail_count    = 0;
            pending_count = 0;
            expiries.delete();
            for (int t = 0; t < TIMER_POOL; t++)
                busy[t] = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expiries.size() == 0)
                begin
                    $display("%0t: unexpected result id=%0d last=%0b", $time,
                             expired_id, last);
                    fail_count++;
                end
                else
                begin
                    if (expired_id !== expiries[0].id || last !== expiries[0].last)
                    begin
                        $display("%0t: expected id=%0d last=%0b, got id=%0d last=%0b",
                                 $time, expiries[0].id, expiries[0].last,
                                 expired_id, last);
                        fail_count++;
                    end
                    expiries.delete(0);
                end
            end
            if (in_valid && !in_stall)
            begin
                case (htw_cmd_t'(cmd))
                    CMD_TICK:   tick_wheel();
                    CMD_SCHED:
                        if (timer_id < TIMER_POOL)
                            put_timer(timer_id, now_tick, now_tick + timeout_ticks);
                    CMD_CANCEL:
                        for (int t = 0; t < TIMER_POOL; t++)
                            busy[t] = 1'b0;
                    default: ;
                endcase
            end
            pending_count = expiries.size();
        end
    end

endmodule

/* bench/tb_hierarchical_timer_wheel.sv */
// ----------------------------------------------------------------------------
// tb_hierarchical_timer_wheel
// Sends schedule, tick, cancel and no-op transfers into the wheel under random
// idling on both sides; the checker beside the block predicts every expiry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hierarchical_timer_wheel;
    import htw_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        cmd;
    logic [ID_W-1:0]   timer_id;
    logic [TO_W-1:0]   timeout_ticks;
    logic              out_valid;
    logic              out_stall;
    logic [ID_W-1:0]   expired_id;
    logic              last;
    int                fail_count;
    int                pending_count;
    int                send_idle;
    int                recv_idle;

    hierarchical_timer_wheel DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .timer_id(timer_id), .timeout_ticks(timeout_ticks),
        .out_valid(out_valid), .out_stall(out_stall), .expired_id(expired_id),
        .last(last)
    );

    htw_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .timer_id(timer_id), .timeout_ticks(timeout_ticks),
        .out_valid(out_valid), .out_stall(out_stall), .expired_id(expired_id),
        .last(last), .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver stalls at random at the current rate.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    // Hold one transfer until it is taken, idling first at the sender rate.
    task automatic send(htw_cmd_t c, logic [ID_W-1:0] id, logic [TO_W-1:0] to);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= c;
        timer_id      <= id;
        timeout_ticks <= to;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic ticks(int n);
        for (int i = 0; i < n; i++)
            send(CMD_TICK, 6'($urandom), $urandom);
    endtask

    function automatic logic [TO_W-1:0] rand_timeout();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(12);
            4, 5:       return $urandom_range(300);
            6:          return $urandom_range(70000);
            7:          return $urandom;
            8:          return 32'hFFFF_FFFF;
            default:    return $urandom_range(3);
        endcase
    endfunction

    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                send(CMD_SCHED, 6'($urandom), rand_timeout());
            else if (r < 93)
                send(CMD_TICK, 6'($urandom), $urandom);
            else if (r < 96)
                send(CMD_NOP, 6'($urandom), $urandom);
            else
                send(CMD_CANCEL, 6'($urandom), $urandom);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_stall     = 1'b0;
        cmd           = CMD_NOP;
        timer_id      = '0;
        timeout_ticks = '0;
        send_idle     = 23;
        recv_idle     = 68;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, several per slot, reschedule, longest delay
        send(CMD_SCHED, 6'd0, 32'd0);
        send(CMD_SCHED, 6'd63, 32'd0);
        send(CMD_SCHED, 6'd5, 32'd1);
        send(CMD_TICK, 6'd63, 32'hFFFF_FFFF);
        send(CMD_TICK, 6'd0, 32'd0);
        send(CMD_SCHED, 6'd9, 32'hFFFF_FFFF);
        send(CMD_SCHED, 6'd10, 32'd300);
        send(CMD_SCHED, 6'd11, 32'd70000);
        send(CMD_SCHED, 6'd12, 32'd2);
        send(CMD_SCHED, 6'd12, 32'd4);
        send(CMD_SCHED, 6'd42, 32'h0100_0000);
        send(CMD_NOP, 6'd21, 32'h5555_5555);
        ticks(5);
        send(CMD_CANCEL, 6'd0, 32'd0);
        ticks(2);
        send(CMD_SCHED, 6'd1, 32'd260);
        send(CMD_SCHED, 6'd2, 32'd255);
        send(CMD_SCHED, 6'd3, 32'd256);

        random_phase(60);
        send_idle = 68;
        recv_idle = 23;
        random_phase(60);
        send_idle = 0;
        recv_idle = 0;
        random_phase(60);

        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/htw_pkg.sv
hw/rtl/htw_ram.sv
hw/rtl/htw_datapath.sv
hw/rtl/htw_ctrl.sv
hw/rtl/hierarchical_timer_wheel.sv
hw/rtl/htw_checker.sv
bench/htw_checker.sv
bench/tb_hierarchical_timer_wheel.sv
